FILE: hw/rtl/pcmf_pkg.sv
// Shared types and constants for the PCM-to-float frame converter.
package pcmf_pkg;

  typedef enum logic [1:0] {
    FMT_S16   = 2'd0,
    FMT_S24   = 2'd1,
    FMT_S32   = 2'd2,
    FMT_FLOAT = 2'd3
  } sample_format_t;

  typedef enum logic {
    REG_SAMPLE_FORMAT  = 1'b0,
    REG_FRAME_CHANNELS = 1'b1
  } reg_index_t;

  localparam int unsigned CFG_WIDTH = 7;

  typedef struct packed {
    logic [31:0] raw_sample;
    logic        block_end;
  } in_item_t;

  typedef struct packed {
    logic [31:0] left_float;
    logic [31:0] right_float;
    logic        last_frame;
  } out_item_t;

endpackage

FILE: hw/rtl/pcmf_convert.sv
// Combinational sample-to-float32 conversion for all source formats.
module pcmf_convert (
  input  pcmf_pkg::sample_format_t fmt,
  input  logic [31:0]              raw,
  output logic [31:0]              result
);
  import pcmf_pkg::*;

  logic [31:0] v;
  logic [31:0] mag;
  logic        neg;
  logic [7:0]  scale;
  logic [4:0]  p;
  logic        found;
  logic [31:0] norm;
  logic [23:0] keep;
  logic        guard;
  logic        sticky;
  logic        round_up;
  logic [24:0] rounded;
  logic [7:0]  expo;

  always_comb begin
    v     = raw;
    scale = 8'd31;
    unique case (fmt)
      FMT_S16: begin
        v     = {{16{raw[15]}}, raw[15:0]};
        scale = 8'd15;
      end
      FMT_S24: v = {raw[23:0], 8'd0};
      FMT_S32, FMT_FLOAT: v = raw;
      default: v = raw;
    endcase
  end

  assign neg = v[31];
  assign mag = neg ? (32'd0 - v) : v;

  // leading-one position
  always_comb begin
    p     = 5'd0;
    found = 1'b0;
    for (int i = 31; i >= 0; i--) begin
      if (!found && mag[i]) begin
        p     = 5'(i);
        found = 1'b1;
      end
    end
  end

  assign norm     = mag << (5'd31 - p);
  assign keep     = norm[31:8];
  assign guard    = norm[7];
  assign sticky   = |norm[6:0];
  assign round_up = guard && (sticky || keep[0]);
  assign rounded  = {1'b0, keep} + {24'd0, round_up};
  assign expo     = 8'({3'd0, p} + 8'd127 - scale + {7'd0, rounded[24]});

  always_comb begin
    if (fmt == FMT_FLOAT) begin
      result = raw;
    end else if (mag == 32'd0) begin
      result = 32'd0;
    end else begin
      result = {neg, expo, rounded[24] ? rounded[23:1] : rounded[22:0]};
    end
  end

endmodule

FILE: hw/rtl/pcm_to_float_frame_converter_top.sv
// Top level: builds stereo float32 frames from interleaved PCM samples.
// One sample is taken per cycle, sustained, with stall low; a result is
// registered as the frame's last sample is taken and is held in an output
// register with a one-entry skid, so input keeps flowing while a result waits.
// Conversion is a single pass of leading-one detect, shift and round-to-even
// between the input handshake and the result register.
module pcm_to_float_frame_converter_top #(
  parameter int unsigned MAX_CHANNELS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  pcmf_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output pcmf_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [pcmf_pkg::CFG_WIDTH-1:0]      cfg_data
);
  import pcmf_pkg::*;

  localparam int unsigned PW = $clog2(MAX_CHANNELS);

  sample_format_t   sample_format;
  logic [6:0]       frame_channels;
  logic [PW-1:0]    channel_position;
  logic [31:0]      held_left;
  logic [31:0]      conv;
  logic [PW:0]      last_ch;
  logic [7:0]       n_clamped;
  logic             in_fire;
  logic             frame_done;

  out_item_t        out_reg;
  logic             skid_valid;
  out_item_t        skid_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format  <= FMT_S16;
      frame_channels <= 7'd2;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_SAMPLE_FORMAT:  sample_format  <= sample_format_t'(cfg_data[1:0]);
        REG_FRAME_CHANNELS: frame_channels <= cfg_data;
        default: ;
      endcase
    end
  end

  pcmf_convert u_convert (
    .fmt    (sample_format),
    .raw    (in_data.raw_sample),
    .result (conv)
  );

  always_comb begin
    n_clamped = {1'b0, frame_channels};
    if (n_clamped == 8'd0) n_clamped = 8'd1;
    if (32'(n_clamped) > MAX_CHANNELS) n_clamped = 8'(MAX_CHANNELS);
    last_ch = (PW+1)'(n_clamped - 8'd1);
  end

  assign in_stall   = skid_valid;
  assign in_fire    = in_valid && !in_stall;
  assign frame_done = {1'b0, channel_position} >= last_ch;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_position <= '0;
      held_left        <= '0;
    end else if (in_fire) begin
      if (channel_position == '0) held_left <= conv;
      channel_position <= frame_done ? '0 : channel_position + 1'b1;
    end
  end

  out_item_t new_item;
  always_comb begin
    new_item.left_float  = (channel_position == '0) ? conv : held_left;
    new_item.right_float = conv;
    new_item.last_frame  = in_data.block_end;
  end

  // output register plus one skid entry; input is stalled while the skid is full
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && skid_valid) begin
        out_reg    <= skid_reg;
        skid_valid <= 1'b0;
      end else if (in_fire && frame_done) begin
        if (!out_valid || !out_stall) begin
          out_reg   <= new_item;
          out_valid <= 1'b1;
        end else begin
          skid_reg   <= new_item;
          skid_valid <= 1'b1;
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_data = out_reg;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid) else $error("skid full with output empty");
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, channel_position} < (PW+1)'(MAX_CHANNELS))
    else $error("channel position out of range");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");

endmodule
